[sv/tshpc_pkg.sv]
`default_nettype none

package tshpc_pkg;

    // table geometry, fixed by the 13-bit pid
    localparam int unsigned PID_W     = 13;
    localparam int unsigned PID_COUNT = 8192;
    localparam int unsigned ENTRY_W   = 5;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_TUSER_W = 2;

    localparam logic [7:0]         SYNC_VALUE     = 8'h47;
    localparam logic [PID_W-1:0]   NULL_PID       = 13'h1FFF;
    localparam logic [PID_W-1:0]   PID_RSV_LO     = 13'd2;
    localparam logic [PID_W-1:0]   PID_RSV_HI     = 13'd15;
    localparam logic [7:0]         MAX_ADAPT_ONLY = 8'd183;
    localparam logic [7:0]         MAX_ADAPT_BOTH = 8'd182;
    localparam logic [7:0]         HEADER_BYTES   = 8'd4;
    localparam logic [7:0]         PAYLOAD_BYTES  = 8'd184;
    localparam logic [7:0]         BOTH_OFFSET    = 8'd5;
    localparam logic [7:0]         BOTH_SIZE      = 8'd183;
    localparam logic [ENTRY_W-1:0] NO_COUNTER     = 5'h10;

    // adaptation field control codes
    localparam logic [1:0] AFC_RESERVED = 2'd0;
    localparam logic [1:0] AFC_PAYLOAD  = 2'd1;
    localparam logic [1:0] AFC_ADAPT    = 2'd2;
    localparam logic [1:0] AFC_BOTH     = 2'd3;

    // scrambling code that the format forbids
    localparam logic [1:0] SCR_RESERVED = 2'd1;

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_FORMAT     = 2'd1,
        ST_TRANSPORT  = 2'd2,
        ST_CONTINUITY = 2'd3
    } status_t;

    // one decoded header as it travels from the front end to the back end
    typedef struct packed {
        status_t            status;
        logic [PID_W-1:0]   pid;
        logic               unit_start;
        logic               prio;
        logic [1:0]         scr;
        logic [1:0]         afc;
        logic [3:0]         cc;
        logic [7:0]         alen;
        logic [7:0]         aflags;
        logic [7:0]         poff;
        logic [7:0]         psize;
        logic               do_update;
    } item_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_stat_t;

endpackage

`default_nettype wire

[sv/tshpc_ram.sv]
`default_nettype none

module tshpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/tshpc_front.sv]
`default_nettype none

module tshpc_front (
    input  wire logic [tshpc_pkg::S_TDATA_W-1:0] tdata,
    input  wire logic [tshpc_pkg::S_TUSER_W-1:0] tuser,
    output      tshpc_pkg::item_t                item
);

    import tshpc_pkg::*;

    logic [7:0]       b0, b1, b2, b3, b4, b5;
    logic [PID_W-1:0] pid;
    logic [1:0]       afc;
    logic [7:0]       alen;
    status_t          status;

    assign b0  = tdata[7:0];
    assign b1  = tdata[15:8];
    assign b2  = tdata[23:16];
    assign b3  = tdata[31:24];
    assign b4  = tdata[39:32];
    assign b5  = tdata[47:40];
    assign pid = {b1[4:0], b2};
    assign afc = b3[5:4];
    assign alen = afc[1] ? b4 : 8'd0;

    // header checks, first failure wins
    always_comb begin
        priority if (b0 != SYNC_VALUE) begin
            status = ST_FORMAT;
        end else if (b1[7]) begin
            status = ST_TRANSPORT;
        end else if (pid >= PID_RSV_LO && pid <= PID_RSV_HI) begin
            status = ST_FORMAT;
        end else if (b3[7:6] == SCR_RESERVED) begin
            status = ST_FORMAT;
        end else if (afc == AFC_RESERVED) begin
            status = ST_FORMAT;
        end else if (afc == AFC_ADAPT && alen > MAX_ADAPT_ONLY) begin
            status = ST_FORMAT;
        end else if (afc == AFC_BOTH && alen > MAX_ADAPT_BOTH) begin
            status = ST_FORMAT;
        end else begin
            status = ST_VALID;
        end
    end

    always_comb begin
        item            = '0;
        item.status     = status;
        item.pid        = pid;
        item.unit_start = b1[6];
        item.prio       = b1[5];
        item.scr        = b3[7:6];
        item.afc        = afc;
        item.cc         = b3[3:0];
        item.alen       = alen;
        item.aflags     = (afc[1] && b4 != 8'd0) ? b5 : 8'd0;
        item.do_update  = (status == ST_VALID) && tuser[0] && (pid != NULL_PID);
        if (afc == AFC_PAYLOAD) begin
            item.poff  = HEADER_BYTES;
            item.psize = PAYLOAD_BYTES;
        end else if (afc == AFC_BOTH && alen <= MAX_ADAPT_BOTH) begin
            item.poff  = alen + BOTH_OFFSET;
            item.psize = BOTH_SIZE - alen;
        end else begin
            item.poff  = 8'd0;
            item.psize = 8'd0;
        end
    end

endmodule

`default_nettype wire

[sv/tshpc_queue.sv]
`default_nettype none

module tshpc_queue #(
    parameter int unsigned DEPTH = tshpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire tshpc_pkg::item_t push_item,
    output      logic             full,
    input  wire logic             pop,
    output      logic             empty,
    output      tshpc_pkg::item_t head
);

    import tshpc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

[sv/tshpc_back.sv]
`default_nettype none

module tshpc_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_empty,
    input  wire tshpc_pkg::item_t     q_head,
    output      tshpc_pkg::back_stat_t stat,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      tshpc_pkg::item_t     out_item
);

    import tshpc_pkg::*;

    // clearing pass
    logic [PID_W-1:0]   clear_cnt_reg, clear_cnt_next;
    logic               clearing_reg, clearing_next;
    // lookup stage
    logic               b_valid_reg, b_valid_next;
    item_t              b_item_reg, b_item_next;
    logic               fwd_hit_reg, fwd_hit_next;
    logic [ENTRY_W-1:0] fwd_data_reg, fwd_data_next;
    // result register
    logic               out_valid_reg, out_valid_next;
    item_t              out_item_reg, out_item_next;

    logic               b_done, b_free, pop;
    logic [ENTRY_W-1:0] rd_data, prev_entry, new_entry, wdata;
    logic [3:0]         prev_inc;
    logic               cont_err, we;
    logic [PID_W-1:0]   waddr;
    item_t              b_result;

    tshpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PID_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (pop),
        .raddr (q_head.pid),
        .rdata (rd_data)
    );

    always_comb begin
        b_done = b_valid_reg && (!out_valid_reg || out_ready);
        b_free = !b_valid_reg || b_done;
        pop    = !q_empty && b_free && !clearing_reg;

        // previous write lands at the edge of our read, so take it from the bypass
        prev_entry = fwd_hit_reg ? fwd_data_reg : rd_data;
        new_entry  = b_item_reg.afc[0] ? {1'b0, b_item_reg.cc} : NO_COUNTER;
        prev_inc   = prev_entry[3:0] + 4'd1;
        cont_err   = !b_item_reg.aflags[7] && !prev_entry[4] && !new_entry[4]
                     && (prev_inc != new_entry[3:0]);

        b_result = b_item_reg;
        if (b_item_reg.do_update && cont_err) begin
            b_result.status = ST_CONTINUITY;
        end

        we    = clearing_reg || (b_done && b_item_reg.do_update);
        waddr = clearing_reg ? clear_cnt_reg : b_item_reg.pid;
        wdata = clearing_reg ? NO_COUNTER : new_entry;

        clear_cnt_next = clearing_reg ? clear_cnt_reg + 1'b1 : clear_cnt_reg;
        clearing_next  = clearing_reg && (clear_cnt_reg != PID_W'(PID_COUNT - 1));

        b_valid_next  = pop ? 1'b1 : (b_done ? 1'b0 : b_valid_reg);
        b_item_next   = pop ? q_head : b_item_reg;
        fwd_hit_next  = pop ? (b_done && b_item_reg.do_update && b_item_reg.pid == q_head.pid)
                            : fwd_hit_reg;
        fwd_data_next = pop ? new_entry : fwd_data_reg;

        out_valid_next = b_done ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_item_next  = b_done ? b_result : out_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
            clearing_reg  <= 1'b1;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clear_cnt_reg <= clear_cnt_next;
            clearing_reg  <= clearing_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_item_reg   <= b_item_next;
        fwd_hit_reg  <= fwd_hit_next;
        fwd_data_reg <= fwd_data_next;
        out_item_reg <= out_item_next;
    end

    assign stat.clearing = clearing_reg;
    assign stat.pop      = pop;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;

`ifndef SYNTH
    a_no_pop_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !pop && !b_valid_reg)
        else $error("lookup active during table clear");

    a_clear_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> clear_cnt_reg == '0)
        else $error("table clear ended early");

    a_status_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        b_done && !b_item_reg.do_update |=> out_item_reg.status == $past(b_item_reg.status))
        else $error("status changed without a table update");
`endif

endmodule

`default_nettype wire

[sv/ts_header_parse_continuity.sv]
// transport stream header parser with per-pid continuity tracking
//
// s_axis: one word per packet, the first six header bytes in tdata (byte 0 in
//   the low bits) and the continuity-check request in tuser
// m_axis: one word per accepted input word, decoded header fields, adaptation
//   length and flags, payload offset and size in tdata, status in tuser
// throughput: one word per cycle while m_axis_tready is high; one table
//   read-modify-write per cycle in the back end on the single-port-pair table
//   ram, the write of the word ahead bypassed into the read of the next one
// path: an accepted word passes the queue register, the table read and the
//   result register before m_axis_tvalid rises
// reset: after aresetn goes high the 8192-entry table is swept to "no counter",
//   one entry a cycle, and s_axis_tready stays low until the sweep is done
// stall: when m_axis_tready is low the result register holds, the back end
//   stops, and the front keeps taking words until the queue is full
`default_nettype none

module ts_header_parse_continuity #(
    parameter int unsigned QUEUE_DEPTH = tshpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // sync_byte, flags_pid_high, pid_low, control_byte,
    // adapt_length_byte, adapt_flags_byte
    input  wire logic [tshpc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // check_continuity
    input  wire logic [tshpc_pkg::S_TUSER_W-1:0]    s_axis_tuser,

    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // pid, unit_start, transport_priority, scrambling_control,
    // adaptation_control, continuity_value, adaptation_length,
    // adaptation_flags, payload_offset, payload_size, one zero pad bit
    output      logic [tshpc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // status
    output      logic [tshpc_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

    import tshpc_pkg::*;

    item_t      dec_item;
    item_t      q_head;
    item_t      res_item;
    logic       q_full, q_empty;
    logic       push;
    back_stat_t back_stat;

    // front end: decode and classify the header
    tshpc_front u_front (
        .tdata (s_axis_tdata),
        .tuser (s_axis_tuser),
        .item  (dec_item)
    );

    // no words taken while the table is being cleared
    assign s_axis_tready = !q_full && !back_stat.clearing;
    assign push          = s_axis_tvalid && s_axis_tready;

    tshpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (dec_item),
        .full      (q_full),
        .pop       (back_stat.pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // back end: continuity table and result register
    tshpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .stat      (back_stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (res_item)
    );

    assign m_axis_tdata = {1'b0, res_item.psize, res_item.poff, res_item.aflags,
                           res_item.alen, res_item.cc, res_item.afc, res_item.scr,
                           res_item.prio, res_item.unit_start, res_item.pid};
    assign m_axis_tuser = res_item.status;

`ifndef SYNTH
    a_ready_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.clearing |-> !s_axis_tready && q_empty)
        else $error("input taken during table clear");
`endif

endmodule

`default_nettype wire

[verif/tb_ts_header_parse_continuity.sv]
`timescale 1ns / 1ps

module tb_ts_header_parse_continuity;
    import tshpc_pkg::*;

    // idle cycles without any word moving on either side before the run is called dead;
    // the table sweep after reset alone holds s_axis_tready low through all PID_COUNT entries
    localparam int unsigned IDLE_LIMIT = 3 * PID_COUNT;
    // cycles to linger once the last result is in
    localparam int unsigned DRAIN_CYCLES = 8;
    // pids that the well-formed streams cycle through
    localparam int unsigned STREAMS = 8;

    // the six header bytes plus the check request, as they go onto s_axis
    typedef struct packed {
        logic       check;
        logic [7:0] aflags;
        logic [7:0] alen;
        logic [7:0] ctrl;
        logic [7:0] pid_lo;
        logic [7:0] flags_hi;
        logic [7:0] sync;
    } ts_hdr_t;

    // decoded header as it comes back on m_axis
    typedef struct {
        status_t          status;
        logic [PID_W-1:0] pid;
        logic             ustart;
        logic             prio;
        logic [1:0]       scr;
        logic [1:0]       afc;
        logic [3:0]       cc;
        logic [7:0]       alen;
        logic [7:0]       aflags;
        logic [7:0]       poff;
        logic [7:0]       psize;
        logic             pad;
    } hdr_fields_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // predictor state: last counter seen per pid, NO_COUNTER when none
    logic [ENTRY_W-1:0] cc_history [PID_COUNT];
    // decoded headers still owed by the block, oldest first
    hdr_fields_t        pending_hdrs [$];

    // stimulus streams: pid and the counter value it should carry next
    logic [PID_W-1:0] stream_pid [STREAMS];
    logic [3:0]       stream_cc [STREAMS];

    int unsigned tx_gap_max   = 0;
    int unsigned rx_stall_max = 0;
    int unsigned headers_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned status_tally [4] = '{default: 0};

    ts_header_parse_continuity i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // sync, flags_pid_high, pid_low, control, adapt length, flags
        .s_axis_tuser  (s_tuser),   // check_continuity
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // pid, ustart, prio, scr, afc, cc, alen, aflags, poff, psize
        .m_axis_tuser  (m_tuser)    // status
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // decode one header and advance the per-pid counter history
    function automatic hdr_fields_t decode_header(ts_hdr_t h);
        hdr_fields_t      r;
        logic             terr;
        logic [ENTRY_W-1:0] old_entry;
        logic [ENTRY_W-1:0] upd_entry;
        logic [3:0]       cc_inc;
        terr     = h.flags_hi[7];
        r.pid    = {h.flags_hi[4:0], h.pid_lo};
        r.ustart = h.flags_hi[6];
        r.prio   = h.flags_hi[5];
        r.scr    = h.ctrl[7:6];
        r.afc    = h.ctrl[5:4];
        r.cc     = h.ctrl[3:0];
        r.alen   = '0;
        r.aflags = '0;
        r.poff   = '0;
        r.psize  = '0;
        r.pad    = 1'b0;
        r.status = ST_VALID;

        // adaptation flags only count when the field has a nonzero length
        if (r.afc[1]) begin
            r.alen = h.alen;
            if (h.alen != 8'd0) r.aflags = h.aflags;
        end

        if (r.afc == AFC_PAYLOAD) begin
            r.poff  = HEADER_BYTES;
            r.psize = PAYLOAD_BYTES;
        end else if (r.afc == AFC_BOTH && r.alen <= MAX_ADAPT_BOTH) begin
            r.poff  = r.alen + BOTH_OFFSET;
            r.psize = BOTH_SIZE - r.alen;
        end

        // first failing check wins
        if (h.sync != SYNC_VALUE) begin
            r.status = ST_FORMAT;
        end else if (terr) begin
            r.status = ST_TRANSPORT;
        end else if (r.pid >= PID_RSV_LO && r.pid <= PID_RSV_HI) begin
            r.status = ST_FORMAT;
        end else if (r.scr == SCR_RESERVED) begin
            r.status = ST_FORMAT;
        end else if (r.afc == AFC_RESERVED) begin
            r.status = ST_FORMAT;
        end else if (r.afc == AFC_ADAPT && r.alen > MAX_ADAPT_ONLY) begin
            r.status = ST_FORMAT;
        end else if (r.afc == AFC_BOTH && r.alen > MAX_ADAPT_BOTH) begin
            r.status = ST_FORMAT;
        end else if (h.check && r.pid != NULL_PID) begin
            old_entry = cc_history[r.pid];
            // no payload means the next packet on this pid starts fresh
            upd_entry = r.afc[0] ? {1'b0, r.cc} : NO_COUNTER;
            cc_history[r.pid] = upd_entry;
            cc_inc = old_entry[3:0] + 4'd1;
            if (!r.aflags[7] && old_entry < NO_COUNTER && upd_entry < NO_COUNTER &&
                {1'b0, cc_inc} != upd_entry) begin
                r.status = ST_CONTINUITY;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // clean header, no scrambling, priority or unit start
    function automatic ts_hdr_t good_header(logic [PID_W-1:0] pid, logic [1:0] afc,
                                            logic [3:0] cc, logic [7:0] alen,
                                            logic [7:0] aflags, logic check);
        ts_hdr_t h;
        h.sync     = SYNC_VALUE;
        h.flags_hi = {3'b000, pid[12:8]};
        h.pid_lo   = pid[7:0];
        h.ctrl     = {2'b00, afc, cc};
        h.alen     = alen;
        h.aflags   = aflags;
        h.check    = check;
        return h;
    endfunction

    // any pid the format allows, null excluded
    function automatic logic [PID_W-1:0] legal_pid();
        logic [PID_W-1:0] pid;
        do begin
            pid = PID_W'($urandom_range(0, PID_COUNT - 1));
        end while ((pid >= PID_RSV_LO && pid <= PID_RSV_HI) || pid == NULL_PID);
        return pid;
    endfunction

    function automatic logic [1:0] legal_scrambling();
        case ($urandom_range(0, 2))
            0: return 2'd0;
            1: return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    // next packet of one of the well-formed streams, counter mostly in sequence
    function automatic ts_hdr_t stream_header();
        ts_hdr_t     h;
        int unsigned sel;
        int unsigned roll;
        logic [1:0]  afc;
        logic [3:0]  cc;
        logic [7:0]  alen;
        logic [7:0]  aflags;
        sel  = $urandom_range(0, STREAMS - 1);
        roll = $urandom_range(0, 99);
        afc  = (roll < 60) ? AFC_PAYLOAD : (roll < 85) ? AFC_BOTH : AFC_ADAPT;
        cc   = ($urandom_range(0, 99) < 88) ? stream_cc[sel] : 4'($urandom);

        roll = $urandom_range(0, 99);
        if (afc == AFC_BOTH) begin
            alen = (roll < 70) ? 8'($urandom_range(0, 12)) :
                   (roll < 90) ? 8'($urandom_range(0, MAX_ADAPT_BOTH)) :
                                 8'($urandom_range(MAX_ADAPT_BOTH - 1, MAX_ADAPT_BOTH));
        end else begin
            alen = (roll < 80) ? 8'($urandom_range(0, MAX_ADAPT_ONLY)) :
                                 8'($urandom_range(MAX_ADAPT_ONLY - 1, MAX_ADAPT_ONLY));
        end
        aflags = 8'($urandom);
        // discontinuity indicator only now and then
        if ($urandom_range(0, 99) < 85) aflags[7] = 1'b0;

        h = good_header(stream_pid[sel], afc, cc, alen, aflags, $urandom_range(0, 9) != 0);
        h.ctrl[7:6]     = legal_scrambling();
        h.flags_hi[6:5] = 2'($urandom);
        if (afc[0]) stream_cc[sel] = cc + 4'd1;
        return h;
    endfunction

    // a header on a random pid with one chosen format or transport fault; a random length may add a second
    function automatic ts_hdr_t broken_header();
        ts_hdr_t h;
        h = good_header(legal_pid(), AFC_PAYLOAD, 4'($urandom), 8'($urandom),
                        8'($urandom), 1'($urandom));
        h.ctrl[5:4]     = 2'($urandom_range(1, 3));
        h.ctrl[7:6]     = legal_scrambling();
        h.flags_hi[6:5] = 2'($urandom);
        case ($urandom_range(0, 6))
            0: begin
                h.sync = 8'($urandom_range(0, 254));
                if (h.sync >= SYNC_VALUE) h.sync = h.sync + 8'd1;
            end
            1: h.flags_hi[7] = 1'b1;
            2: begin
                h.flags_hi[4:0] = 5'd0;
                h.pid_lo        = 8'($urandom_range(PID_RSV_LO, PID_RSV_HI));
            end
            3: h.ctrl[7:6] = SCR_RESERVED;
            4: h.ctrl[5:4] = AFC_RESERVED;
            5: begin
                h.ctrl[5:4] = AFC_ADAPT;
                h.alen      = 8'($urandom_range(MAX_ADAPT_ONLY + 1, 255));
            end
            default: begin
                h.ctrl[5:4] = AFC_BOTH;
                h.alen      = 8'($urandom_range(MAX_ADAPT_BOTH + 1, 255));
            end
        endcase
        return h;
    endfunction

    // present one header word, wait for the handshake, then log the expected decode
    task automatic send_header(input ts_hdr_t h);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {h.aflags, h.alen, h.ctrl, h.pid_lo, h.flags_hi, h.sync};
        s_tuser  <= h.check;
        do @(posedge aclk); while (!s_tready);
        pending_hdrs.push_back(decode_header(h));
        headers_sent++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every format and transport check, its priority, and the length limits
    task automatic test_header_format();
        ts_hdr_t h;
        tx_gap_max   = 3;
        rx_stall_max = 3;
        // bad sync wins over a transport error
        h = good_header(13'h0100, AFC_PAYLOAD, 4'd0, 8'd0, 8'd0, 1'b1);
        h.sync = 8'hFF;
        h.flags_hi[7] = 1'b1;
        send_header(h);
        // transport error wins over a reserved pid
        h = good_header(13'd2, AFC_PAYLOAD, 4'd0, 8'd0, 8'd0, 1'b1);
        h.flags_hi[7] = 1'b1;
        send_header(h);
        // reserved pid range edges, and the legal neighbor below
        send_header(good_header(13'd2, AFC_PAYLOAD, 4'd1, 8'd0, 8'd0, 1'b1));
        send_header(good_header(13'd15, AFC_PAYLOAD, 4'd2, 8'd0, 8'd0, 1'b1));
        send_header(good_header(13'd1, AFC_PAYLOAD, 4'd3, 8'd0, 8'd0, 1'b1));
        // forbidden scrambling code
        h = good_header(13'h0200, AFC_PAYLOAD, 4'd4, 8'd0, 8'd0, 1'b1);
        h.ctrl[7:6] = SCR_RESERVED;
        send_header(h);
        // reserved adaptation control
        send_header(good_header(13'h0201, AFC_RESERVED, 4'd5, 8'd7, 8'hFF, 1'b1));
        // adaptation only, at and over the limit
        send_header(good_header(13'h0202, AFC_ADAPT, 4'd6, MAX_ADAPT_ONLY, 8'hFF, 1'b1));
        send_header(good_header(13'h0203, AFC_ADAPT, 4'd7, MAX_ADAPT_ONLY + 8'd1, 8'hFF,
                                1'b1));
        // adaptation with payload, at the limit (one payload byte) and far over it
        send_header(good_header(13'h0204, AFC_BOTH, 4'd8, MAX_ADAPT_BOTH, 8'h7F, 1'b1));
        send_header(good_header(13'h0205, AFC_BOTH, 4'd9, 8'd255, 8'hFF, 1'b1));
        // zero length: flags read as zero
        send_header(good_header(13'h0206, AFC_BOTH, 4'd10, 8'd0, 8'hFF, 1'b1));
        send_header(good_header(13'h0207, AFC_ADAPT, 4'd11, 8'd0, 8'hFF, 1'b1));
        // null pid with all flag bits set except the error bit
        h = good_header(NULL_PID, AFC_PAYLOAD, 4'd15, 8'd0, 8'd0, 1'b1);
        h.flags_hi[6:5] = 2'b11;
        h.ctrl[7:6] = 2'd3;
        send_header(h);
    endtask

    // counter sequences: gap, discontinuity, no payload, checking off on pid 16, then a wrap on pid 8190
    task automatic test_continuity();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        send_header(good_header(13'd16, AFC_PAYLOAD, 4'd0, 8'd0, 8'd0, 1'b1));
        send_header(good_header(13'd16, AFC_PAYLOAD, 4'd1, 8'd0, 8'd0, 1'b1));
        // skipped counter
        send_header(good_header(13'd16, AFC_PAYLOAD, 4'd3, 8'd0, 8'd0, 1'b1));
        // jump excused by the discontinuity indicator
        send_header(good_header(13'd16, AFC_BOTH, 4'd5, 8'd1, 8'h80, 1'b1));
        // indicator does not count with zero adaptation length
        send_header(good_header(13'd16, AFC_BOTH, 4'd5, 8'd0, 8'h80, 1'b1));
        // adaptation only clears the history, so any counter after it is fine
        send_header(good_header(13'd16, AFC_ADAPT, 4'd5, 8'd4, 8'h00, 1'b1));
        send_header(good_header(13'd16, AFC_PAYLOAD, 4'd9, 8'd0, 8'd0, 1'b1));
        // checking off leaves the history at 9
        send_header(good_header(13'd16, AFC_PAYLOAD, 4'd10, 8'd0, 8'd0, 1'b0));
        send_header(good_header(13'd16, AFC_PAYLOAD, 4'd11, 8'd0, 8'd0, 1'b1));
        // counter wrap
        send_header(good_header(13'd8190, AFC_PAYLOAD, 4'd15, 8'd0, 8'd0, 1'b1));
        send_header(good_header(13'd8190, AFC_PAYLOAD, 4'd0, 8'd0, 8'd0, 1'b1));
    endtask

    // well-formed streams with random content, sprinkled with broken and raw words
    task automatic test_random_streams(input int unsigned n, input int unsigned gap_max,
                                       input int unsigned stall_max);
        int unsigned roll;
        tx_gap_max   = gap_max;
        rx_stall_max = stall_max;
        stream_pid[0] = 13'd0;
        stream_pid[1] = 13'd1;
        stream_pid[2] = 13'd16;
        stream_pid[3] = 13'd8190;
        for (int i = 4; i < STREAMS; i++) stream_pid[i] = legal_pid();
        for (int i = 0; i < STREAMS; i++) stream_cc[i] = 4'($urandom);
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 78)      send_header(stream_header());
            else if (roll < 90) send_header(broken_header());
            else                send_header(ts_hdr_t'({$urandom, $urandom}));
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // result channel back-pressure, drawn per word
    initial begin
        int unsigned stall;
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: result %0d field %s: expected 0x%0h, actual 0x%0h",
                     $time, results_seen, name, want, got);
            mismatches++;
        end
    endtask

    // compare each accepted result word against the oldest expected decode
    always @(posedge aclk) begin
        hdr_fields_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hdrs.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual tdata 0x%0h tuser %0d",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_hdrs.pop_front();
                status_tally[want.status]++;
                check_field("status", want.status, m_tuser);
                check_field("pid", want.pid, m_tdata[12:0]);
                check_field("unit_start", want.ustart, m_tdata[13]);
                check_field("priority", want.prio, m_tdata[14]);
                check_field("scrambling", want.scr, m_tdata[16:15]);
                check_field("adapt_control", want.afc, m_tdata[18:17]);
                check_field("continuity", want.cc, m_tdata[22:19]);
                check_field("adapt_length", want.alen, m_tdata[30:23]);
                check_field("adapt_flags", want.aflags, m_tdata[38:31]);
                check_field("payload_offset", want.poff, m_tdata[46:39]);
                check_field("payload_size", want.psize, m_tdata[54:47]);
                check_field("pad", want.pad, m_tdata[55]);
            end
            results_seen++;
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_hdrs.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        for (int i = 0; i < PID_COUNT; i++) cc_history[i] = NO_COUNTER;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_header_format();
        test_continuity();
        // mixed idling, then back-to-back, then one side at a time
        test_random_streams(450, 6, 6);
        test_random_streams(300, 0, 0);
        test_random_streams(350, 0, 6);
        test_random_streams(325, 6, 0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_hdrs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d headers and %0d result words across four idling mixes",
                 headers_sent, results_seen);
        $display("statuses: valid %0d, format %0d, transport %0d, continuity %0d",
                 status_tally[ST_VALID], status_tally[ST_FORMAT],
                 status_tally[ST_TRANSPORT], status_tally[ST_CONTINUITY]);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
